/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL files of the prefix-code emitter.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked property that is ignored while the reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked property that must hold at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/pces_pkg.sv */
// Package of the prefix-code emitter: payload types, codes, constants
// and the controller/datapath command and status structs. No dependencies.
`default_nettype none

package pces_pkg;

  localparam int SymbolCount = 256;
  // Longest code length kept in the table; longer loads saturate to it.
  localparam int MaxCodeLen  = 16;
  // Five equal code bits in a row force a stuffed bit of the other value.
  localparam int RunLimit    = 5;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpEncode = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  symbol;
    logic [15:0] code_word;
    logic [4:0]  code_length;
    logic        start_of_message;
  } in_item_t;

  typedef struct packed {
    logic out_bit;
    logic last;
    logic no_code;
  } out_item_t;

  typedef struct packed {
    logic [15:0] word;
    logic [4:0]  len;
  } entry_t;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StEmit
  } state_e;

  typedef struct packed {
    logic load;    // write the table entry of the transfer on the input
    logic lookup;  // read the table for the encode transfer on the input
    logic start;   // table data is ready: set up the bit sequencer
    logic emit;    // put the next result into the output register
  } cmd_t;

  typedef struct packed {
    logic slot_free;  // output register can take a result this cycle
    logic final_bit;  // the result that would be emitted now ends the symbol
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/pces_stream_if.sv */
// Valid/ready stream interface used for the input and the result channel.
// The payload type is set by the instance; no other dependencies.
`default_nettype none

interface pces_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/prefix_code_emit_with_bit_stuffing.sv */
// Top level of the prefix-code emitter with bit stuffing. Depends on
// pces_pkg, pces_stream_if, pces_ctrl, pces_dp and assert_macros.svh.
//
// This block turns byte symbols into a serial bit stream through a
// programmable table of prefix codes. A load transfer (op = 0) writes the
// code word and length of one symbol and produces no result; lengths
// above the table limit are clipped to it, and loads to symbols beyond
// the table are dropped. An encode transfer (op = 1) reads the table and
// sends the code one bit per result transfer, first bit first, inserting
// a 1 after five 0s in a row and a 0 after five 1s in a row. The run
// counters carry across symbols and are cleared by start_of_message on an
// encode transfer. A symbol without a code gives a single result with
// no_code set. The last result of every symbol has last set, even when it
// is a stuffed bit. An encode goes through the table read and then the
// setup of the bit sequencer; its results are the code bits plus the
// stuffed bits. The bit sequencer sends one bit per cycle from the code
// register while the result channel does not stall. Items are handled one
// at a time: the input is ready only between symbols. The table comes out
// of reset empty at once, through a valid flag per entry, so no clearing
// pass is needed.
`default_nettype none

`include "assert_macros.svh"

module prefix_code_emit_with_bit_stuffing #(
  parameter int SYMBOL_COUNT = pces_pkg::SymbolCount
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  pces_stream_if.sink   in_i,
  pces_stream_if.source out_o
);

  pces_pkg::cmd_t    cmd;
  pces_pkg::status_t status;
  logic              in_ready;

  pces_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.data.op),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pces_dp #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.data)
  );

  assign in_i.ready = in_ready;

  // An encode transfer holds off the input for at least the table read.
  `ASSERT_RST(a_encode_blocks_input, clk_i, rst_ni, (in_i.valid && in_ready && (in_i.data.op == pces_pkg::OpEncode)) |=> !in_ready, "input ready right after an encode transfer")
  // Results are only produced while no input transfer can be taken.
  `ASSERT_RST(a_emit_not_idle, clk_i, rst_ni, cmd.emit |-> !in_ready, "result emitted while input is ready")
  // A result for a symbol without code is a single, final zero bit.
  `ASSERT_RST(a_no_code_form, clk_i, rst_ni, (out_o.valid && out_o.data.no_code) |-> (out_o.data.last && !out_o.data.out_bit), "malformed no-code result")
  // The controller never loads and looks up in the same cycle.
  `ASSERT_ALWAYS(a_cmd_exclusive, clk_i, !(cmd.load && cmd.lookup), "load and lookup issued together")

endmodule

`default_nettype wire

/* rtl/core/pces_ctrl.sv */
// Controller of the prefix-code emitter: sequences load, table read and
// bit emission. Depends on pces_pkg.
`default_nettype none

module pces_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_op_i,
  output logic                   in_ready_o,
  input  wire pces_pkg::status_t status_i,
  output pces_pkg::cmd_t         cmd_o
);

  pces_pkg::state_e state_q, state_d;
  logic             accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pces_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    accept     = 1'b0;
    unique case (state_q)
      pces_pkg::StIdle: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
        if (accept && (in_op_i == pces_pkg::OpLoad)) begin
          cmd_o.load = 1'b1;
        end
        if (accept && (in_op_i == pces_pkg::OpEncode)) begin
          cmd_o.lookup = 1'b1;
          state_d      = pces_pkg::StRead;
        end
      end
      pces_pkg::StRead: begin
        cmd_o.start = 1'b1;
        state_d     = pces_pkg::StEmit;
      end
      pces_pkg::StEmit: begin
        cmd_o.emit = status_i.slot_free;
        if (status_i.slot_free && status_i.final_bit) begin
          state_d = pces_pkg::StIdle;
        end
      end
      default: begin
        state_d = pces_pkg::StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/pces_dp.sv */
// Datapath of the prefix-code emitter: code table, bit sequencer, run
// counters and output register. Depends on pces_pkg.
`default_nettype none

module pces_dp #(
  parameter int SYMBOL_COUNT = pces_pkg::SymbolCount
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pces_pkg::in_item_t in_item_i,
  input  wire pces_pkg::cmd_t     cmd_i,
  output pces_pkg::status_t       status_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output pces_pkg::out_item_t     out_item_o
);

  localparam int IdxW = $clog2(SYMBOL_COUNT);

  pces_pkg::entry_t mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] valid_q;

  logic [IdxW-1:0]  idx;
  logic             in_range;
  logic [4:0]       len_sat;

  pces_pkg::entry_t rd_q;
  logic             rd_vld_q;
  logic             in_range_q;

  logic [15:0] word_q, word_d;
  logic [4:0]  pos_q, pos_d;
  logic        nocode_q, nocode_d;
  logic        stuff_q, stuff_d;
  logic        stuff_val_q, stuff_val_d;
  logic [2:0]  zero_run_q, zero_run_d;
  logic [2:0]  one_run_q, one_run_d;

  logic                out_valid_q, out_valid_d;
  pces_pkg::out_item_t out_q, out_d;

  logic [4:0] pos_m1;
  logic       code_bit;
  logic [2:0] run_inc;
  logic       run_hit;

  assign idx      = in_item_i.symbol[IdxW-1:0];
  assign in_range = {1'b0, in_item_i.symbol} < 9'(SYMBOL_COUNT);
  assign len_sat  = ({1'b0, in_item_i.code_length} > 6'(pces_pkg::MaxCodeLen)) ?
                    5'(pces_pkg::MaxCodeLen) : in_item_i.code_length;

  // Table storage: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_range) begin
      mem[idx] <= '{word: in_item_i.code_word, len: len_sat};
    end
    if (cmd_i.lookup) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_vld_q   <= 1'b0;
      in_range_q <= 1'b0;
    end else begin
      if (cmd_i.load && in_range) begin
        valid_q[idx] <= 1'b1;
      end
      if (cmd_i.lookup) begin
        rd_vld_q   <= in_range && valid_q[idx];
        in_range_q <= in_range;
      end
    end
  end

  // Next code bit, MSB first; positions above the stored word read as 0.
  assign pos_m1   = pos_q - 5'd1;
  assign code_bit = (pos_m1 < 5'd16) ? word_q[pos_m1[3:0]] : 1'b0;
  assign run_inc  = (code_bit ? one_run_q : zero_run_q) + 3'd1;
  assign run_hit  = (run_inc == 3'(pces_pkg::RunLimit));

  assign status_o.slot_free = !out_valid_q || out_ready_i;
  assign status_o.final_bit = nocode_q || (stuff_q ? (pos_q == 5'd0) :
                              ((pos_q == 5'd1) && !run_hit));

  always_comb begin
    word_d      = word_q;
    pos_d       = pos_q;
    nocode_d    = nocode_q;
    stuff_d     = stuff_q;
    stuff_val_d = stuff_val_q;
    zero_run_d  = zero_run_q;
    one_run_d   = one_run_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (cmd_i.lookup && in_item_i.start_of_message) begin
      zero_run_d = '0;
      one_run_d  = '0;
    end

    if (cmd_i.start) begin
      word_d   = rd_q.word;
      pos_d    = rd_q.len;
      nocode_d = !rd_vld_q || !in_range_q || (rd_q.len == 5'd0);
      stuff_d  = 1'b0;
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_d.last  = status_o.final_bit;
      priority if (nocode_q) begin
        out_d.out_bit = 1'b0;
        out_d.no_code = 1'b1;
      end else if (stuff_q) begin
        out_d.out_bit = stuff_val_q;
        out_d.no_code = 1'b0;
        stuff_d       = 1'b0;
        zero_run_d    = '0;
        one_run_d     = '0;
      end else begin
        out_d.out_bit = code_bit;
        out_d.no_code = 1'b0;
        pos_d         = pos_m1;
        if (run_hit) begin
          stuff_d     = 1'b1;
          stuff_val_d = !code_bit;
          zero_run_d  = '0;
          one_run_d   = '0;
        end else if (code_bit) begin
          zero_run_d = '0;
          one_run_d  = run_inc;
        end else begin
          zero_run_d = run_inc;
          one_run_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nocode_q    <= 1'b0;
      stuff_q     <= 1'b0;
      zero_run_q  <= '0;
      one_run_q   <= '0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      nocode_q    <= nocode_d;
      stuff_q     <= stuff_d;
      zero_run_q  <= zero_run_d;
      one_run_q   <= one_run_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q      <= word_d;
    stuff_val_q <= stuff_val_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for the prefix-code emitter with bit stuffing.
// Depends on pces_pkg, pces_stream_if and the emitter top level; the expected bits come
// from a code table and run counters kept inside the bench, or are typed into a row.
`timescale 1ns / 1ps

module tb;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 64;
  localparam int RandomPerPhase = 135;

  // One row of the directed table. When n is nonzero the expected bits are
  // typed in, first emitted bit at position n - 1; otherwise the code table
  // model below supplies them.
  typedef struct {
    pces_pkg::in_item_t item;
    int unsigned        n;
    logic [19:0]        bits;
    logic               err;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pces_stream_if #(.payload_t(pces_pkg::in_item_t))  in_ch ();
  pces_stream_if #(.payload_t(pces_pkg::out_item_t)) out_ch ();

  prefix_code_emit_with_bit_stuffing dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #4 clk_i = ~clk_i;

  // Code table model and the two run counters.
  logic [15:0] tbl_word [pces_pkg::SymbolCount];
  logic [4:0]  tbl_len  [pces_pkg::SymbolCount];
  logic [2:0]  zero_streak;
  logic [2:0]  one_streak;

  pces_pkg::out_item_t emitted [$];   // bits produced by the model for one transfer
  pces_pkg::out_item_t bits_due [$];  // bits still owed by the block, oldest first
  stim_row_t           directed_rows [$];
  logic [7:0]          known_syms [$];

  int src_idle_pct;
  int sink_idle_pct;
  int mismatches;
  int n_results;
  int quiet_cycles;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Updates the table model for a load, or computes the bits of an encode.
  task automatic emit_code_bits(pces_pkg::in_item_t it);
    logic [4:0]          len;
    logic [15:0]         word;
    pces_pkg::out_item_t r;
    int                  i;
    emitted.delete();
    if (it.op == pces_pkg::OpLoad) begin
      // Overlong lengths are clipped; start_of_message has no effect here.
      len = (it.code_length > pces_pkg::MaxCodeLen) ? 5'(pces_pkg::MaxCodeLen) :
            it.code_length;
      tbl_word[it.symbol] = it.code_word;
      tbl_len[it.symbol]  = len;
      return;
    end
    if (it.start_of_message) begin
      zero_streak = '0;
      one_streak  = '0;
    end
    // With a full 256-entry table every byte is inside it, so only a zero
    // length marks a missing code. The counters stay as they are.
    if (tbl_len[it.symbol] == '0) begin
      r.out_bit = 1'b0;
      r.last    = 1'b1;
      r.no_code = 1'b1;
      emitted.push_back(r);
      return;
    end
    word = tbl_word[it.symbol];
    len  = tbl_len[it.symbol];
    r.last    = 1'b0;
    r.no_code = 1'b0;
    for (i = int'(len) - 1; i >= 0; i--) begin
      r.out_bit = word[i];
      emitted.push_back(r);
      if (word[i] == 1'b0) begin
        one_streak = '0;
        zero_streak++;
        if (zero_streak >= pces_pkg::RunLimit) begin
          r.out_bit = 1'b1;
          emitted.push_back(r);
          zero_streak = '0;
          one_streak  = '0;
        end
      end else begin
        zero_streak = '0;
        one_streak++;
        if (one_streak >= pces_pkg::RunLimit) begin
          r.out_bit = 1'b0;
          emitted.push_back(r);
          zero_streak = '0;
          one_streak  = '0;
        end
      end
    end
    // The final bit of the symbol carries last, stuffed or not.
    r = emitted.pop_back();
    r.last = 1'b1;
    emitted.push_back(r);
  endtask

  function automatic stim_row_t mk_row(logic op, logic [7:0] sym, logic [15:0] word,
                                       logic [4:0] len, logic som, int unsigned n = 0,
                                       logic [19:0] bits = '0, logic err = 1'b0);
    stim_row_t row;
    row.item.op               = op;
    row.item.symbol           = sym;
    row.item.code_word        = word;
    row.item.code_length      = len;
    row.item.start_of_message = som;
    row.n    = n;
    row.bits = bits;
    row.err  = err;
    return row;
  endfunction

  // Mostly encodes of symbols that were loaded, with codes biased toward long
  // runs so that stuffing shows up often, plus loads and some noise.
  function automatic pces_pkg::in_item_t random_item();
    pces_pkg::in_item_t it;
    int                 pick;
    int                 k;
    it.op = ($urandom_range(99) < 28) ? pces_pkg::OpLoad : pces_pkg::OpEncode;
    it.start_of_message = ($urandom_range(99) < 15);
    it.symbol = 8'($urandom_range(255));
    if (it.op == pces_pkg::OpEncode && known_syms.size() != 0 &&
        $urandom_range(99) < 85) begin
      it.symbol = known_syms[$urandom_range(known_syms.size() - 1)];
    end
    pick = $urandom_range(99);
    if (pick < 40) begin
      it.code_word = 16'($urandom);
    end else if (pick < 55) begin
      it.code_word = 16'h0000;
    end else if (pick < 70) begin
      it.code_word = 16'hffff;
    end else begin
      it.code_word[0] = 1'($urandom_range(1));
      for (k = 1; k < 16; k++) begin
        it.code_word[k] = ($urandom_range(99) < 80) ? it.code_word[k-1] : ~it.code_word[k-1];
      end
    end
    pick = $urandom_range(99);
    if (pick < 65) begin
      it.code_length = 5'($urandom_range(8, 1));
    end else if (pick < 85) begin
      it.code_length = 5'($urandom_range(16, 9));
    end else if (pick < 92) begin
      it.code_length = 5'd0;
    end else begin
      it.code_length = 5'($urandom_range(31, 17));
    end
    if (it.op == pces_pkg::OpLoad) begin
      known_syms.push_back(it.symbol);
    end
    return it;
  endfunction

  // Presents one item, waits for its transfer and records what it owes.
  // Valid is only lowered when a gap follows, so it never gets two
  // assignments in one time step.
  task automatic send_row(stim_row_t row);
    pces_pkg::out_item_t r;
    int                  k;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= row.item;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    emit_code_bits(row.item);
    if (row.n != 0) begin
      for (k = int'(row.n) - 1; k >= 0; k--) begin
        r.out_bit = row.bits[k];
        r.last    = (k == 0);
        r.no_code = row.err;
        bits_due.push_back(r);
      end
    end else begin
      foreach (emitted[k]) bits_due.push_back(emitted[k]);
    end
  endtask

  // Result side: random stall pattern set by sink_idle_pct.
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    pces_pkg::out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (bits_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", n_results));
      end else begin
        want = bits_due.pop_front();
        if (out_ch.data.out_bit !== want.out_bit) begin
          report_mismatch($sformatf("result %0d out_bit %b, expected %b",
                                    n_results, out_ch.data.out_bit, want.out_bit));
        end
        if (out_ch.data.last !== want.last) begin
          report_mismatch($sformatf("result %0d last %b, expected %b",
                                    n_results, out_ch.data.last, want.last));
        end
        if (out_ch.data.no_code !== want.no_code) begin
          report_mismatch($sformatf("result %0d no_code %b, expected %b",
                                    n_results, out_ch.data.no_code, want.no_code));
        end
      end
      n_results++;
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int        ph;
    int        k;

    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    out_ch.ready  = 1'b0;
    src_idle_pct  = 23;
    sink_idle_pct = 73;
    mismatches    = 0;
    n_results     = 0;
    quiet_cycles  = 0;
    zero_streak   = '0;
    one_streak    = '0;
    for (k = 0; k < pces_pkg::SymbolCount; k++) begin
      tbl_word[k] = '0;
      tbl_len[k]  = '0;
    end

    // Empty table after reset: both end symbols have no code.
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h00, '0, '0, 1'b1, 1, 20'b0, 1'b1));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'hff, '0, '0, 1'b0, 1, 20'b0, 1'b1));
    // Longest all-ones and all-zeros codes: a stuffed bit after every five.
    directed_rows.push_back(mk_row(pces_pkg::OpLoad,   8'hff, 16'hffff, 5'd16, 1'b0));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'hff, '0, '0, 1'b1, 19,
                                   20'b1111101111101111101));
    directed_rows.push_back(mk_row(pces_pkg::OpLoad,   8'h00, 16'h0000, 5'd16, 1'b1));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h00, '0, '0, 1'b1, 19,
                                   20'b0000010000010000010));
    // Four ones left in the counter, then the all-ones code: the most bits.
    directed_rows.push_back(mk_row(pces_pkg::OpLoad,   8'h01, 16'h000f, 5'd4, 1'b0));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h01, '0, '0, 1'b1, 4, 20'b1111));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'hff, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h01, '0, '0, 1'b0));
    // Overlong length on load is clipped to sixteen.
    directed_rows.push_back(mk_row(pces_pkg::OpLoad,   8'h10, 16'ha5c3, 5'd31, 1'b0));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h10, '0, '0, 1'b1));
    // One-bit code, with junk above the code in the word.
    directed_rows.push_back(mk_row(pces_pkg::OpLoad,   8'h80, 16'hfffe, 5'd1, 1'b0));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h80, '0, '0, 1'b1, 1, 20'b0));
    // Start of message on a symbol without code still clears the counters.
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h01, '0, '0, 1'b1));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h02, '0, '0, 1'b1, 1, 20'b0, 1'b1));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h01, '0, '0, 1'b0, 4, 20'b1111));
    // Start of message on a load is ignored: the ones run carries on.
    directed_rows.push_back(mk_row(pces_pkg::OpLoad,   8'h03, 16'h0001, 5'd1, 1'b1));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h03, '0, '0, 1'b0));
    // Loading length zero removes a code.
    directed_rows.push_back(mk_row(pces_pkg::OpLoad,   8'h01, 16'h1234, 5'd0, 1'b0));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h01, '0, '0, 1'b0, 1, 20'b0, 1'b1));
    // A run that crosses a symbol boundary, and a stuffed bit that is last.
    directed_rows.push_back(mk_row(pces_pkg::OpLoad,   8'h40, 16'h0000, 5'd3, 1'b0));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h40, '0, '0, 1'b1));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h40, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(pces_pkg::OpLoad,   8'h41, 16'h7fe0, 5'd5, 1'b0));
    directed_rows.push_back(mk_row(pces_pkg::OpEncode, 8'h41, '0, '0, 1'b1, 6, 20'b000001));
    known_syms.delete();
    known_syms.push_back(8'hff);
    known_syms.push_back(8'h00);
    known_syms.push_back(8'h10);
    known_syms.push_back(8'h80);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) send_row(directed_rows[k]);

    // Random part in three phases of handshake pressure.
    row.n    = 0;
    row.bits = '0;
    row.err  = 1'b0;
    for (ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 23 : (ph == 1) ? 73 : 0;
      sink_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 23 : 0;
      for (k = 0; k < RandomPerPhase; k++) begin
        row.item = random_item();
        send_row(row);
      end
    end
    in_ch.valid <= 1'b0;

    while (bits_due.size() != 0) @(posedge clk_i);
    // Any stray result after the last expected one is caught here.
    repeat (DrainCycles) @(posedge clk_i);
    if (bits_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", bits_due.size()));
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/pces_pkg.sv
rtl/core/pces_stream_if.sv
rtl/core/pces_ctrl.sv
rtl/core/pces_dp.sv
rtl/core/prefix_code_emit_with_bit_stuffing.sv
bench/tb.sv
